// ----- rtl/core/fps_pkg.sv -----
// ----------------------------------------------------------------------------
// fps_pkg: shared definitions of the fiber pool scheduler
// Request and status codes, default sizes and the controller command type.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int POOL_SIZE_DEF = 32;
  localparam int TAG_BITS_DEF  = 16;

  localparam int REQ_W   = 3;
  localparam int FID_W   = 5;
  localparam int INTAG_W = 16;
  localparam int STAT_W  = 2;

  localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FETCH   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_BLOCK   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DONE    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_UNBLOCK = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADARG = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
  } fps_cmd_t;

endpackage

// ----- rtl/core/fps_ctrl.sv -----
// ----------------------------------------------------------------------------
// fps_ctrl: request sequencer
// Two-state controller that captures a request and then executes it,
// and marks the result cycle with the output strobe.
// ----------------------------------------------------------------------------
module fps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output fps_pkg::fps_cmd_t cmd,
  output logic             out_strobe
);
  import fps_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic strobe_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == S_EXEC);
    end
  end

  assign busy       = (state_r == S_EXEC);
  assign cmd.load   = start && (state_r == S_IDLE);
  assign cmd.exec   = (state_r == S_EXEC);
  assign out_strobe = strobe_r;

endmodule

// ----- rtl/core/fps_dp.sv -----
// ----------------------------------------------------------------------------
// fps_dp: scheduler datapath
// Free and pending stacks in memories, the blocked list as a row of
// shifting cells with parallel tag compare, and the result registers.
// ----------------------------------------------------------------------------
module fps_dp #(
  parameter int POOL_SIZE = fps_pkg::POOL_SIZE_DEF,
  parameter int TAG_BITS  = fps_pkg::TAG_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fps_pkg::fps_cmd_t            cmd,
  input  logic [fps_pkg::REQ_W-1:0]    in_req_type,
  input  logic [fps_pkg::FID_W-1:0]    in_fiber_id,
  input  logic [fps_pkg::INTAG_W-1:0]  in_block_tag,
  output logic [fps_pkg::FID_W-1:0]    out_granted_fiber,
  output logic                         out_fiber_valid,
  output logic [fps_pkg::STAT_W-1:0]   out_status,
  output logic                         out_has_work
);
  import fps_pkg::*;

  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_SIZE);

  // Counts and the free stack low mark; entries below the mark are never written
  // and stand for their reset value, which equals their index.
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic [CNT_W-1:0] blk_cnt_r, blk_cnt_nxt;
  logic [CNT_W-1:0] mark_r, mark_nxt;

  logic [IDX_W-1:0] free_mem [POOL_SIZE];
  logic [IDX_W-1:0] pend_mem [POOL_SIZE];
  logic [IDX_W-1:0] blk_ctx_r [POOL_SIZE];
  logic [TAG_BITS-1:0] blk_tag_r [POOL_SIZE];

  logic [REQ_W-1:0]    req_r;
  logic [FID_W-1:0]    fid_r;
  logic [TAG_BITS-1:0] tag_r;
  logic [POOL_SIZE-1:0] match_r;
  logic [IDX_W-1:0]    frd_r, prd_r, fidx_r;
  logic                flo_r;

  logic [FID_W-1:0]  gnt_r;
  logic              valid_r;
  logic [STAT_W-1:0] stat_r;
  logic              work_r;

  // Input alignment to internal widths.
  logic [TAG_BITS+INTAG_W-1:0] tag_ext;
  logic [TAG_BITS-1:0]         tag_in;
  logic [IDX_W+FID_W-1:0]      fid_ext;
  logic [IDX_W-1:0]            fid_idx;

  assign tag_ext = {{TAG_BITS{1'b0}}, in_block_tag};
  assign tag_in  = tag_ext[TAG_BITS-1:0];
  assign fid_ext = {{IDX_W{1'b0}}, fid_r};
  assign fid_idx = fid_ext[IDX_W-1:0];

  logic [CNT_W-1:0] free_m1, pend_m1;
  assign free_m1 = free_cnt_r - CNT_W'(1);
  assign pend_m1 = pend_cnt_r - CNT_W'(1);

  // Capture stage: request fields, stack top reads and tag compare.
  logic [POOL_SIZE-1:0] match_in;
  always_comb begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      match_in[i] = (CNT_W'(i) < blk_cnt_r) && (blk_tag_r[i] == tag_in);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      fid_r   <= in_fiber_id;
      tag_r   <= tag_in;
      match_r <= match_in;
      fidx_r  <= free_m1[IDX_W-1:0];
      flo_r   <= (free_m1 < mark_r);
    end
  end

  // Execute stage.
  logic [POOL_SIZE-1:0] pm;
  logic [POOL_SIZE-1:0] first;
  logic [IDX_W-1:0]     hit_ctx;
  logic                 hit;

  always_comb begin
    pm = match_r;
    for (int k = 0; k < IDX_W; k++) begin
      pm = pm | (pm << (1 << k));
    end
    first   = match_r & ~(pm << 1);
    hit     = pm[POOL_SIZE-1];
    hit_ctx = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      hit_ctx = hit_ctx | (first[i] ? blk_ctx_r[i] : '0);
    end
  end

  logic              fid_bad;
  logic              free_wr, pend_wr, blk_app, blk_shift;
  logic [IDX_W-1:0]  gnt_idx;
  logic [STAT_W-1:0] stat_nxt;
  logic              valid_nxt;
  logic [IDX_W+FID_W-1:0] gnt_ext;

  assign fid_bad = (32'(fid_r) >= POOL_SIZE);

  always_comb begin
    free_cnt_nxt = free_cnt_r;
    pend_cnt_nxt = pend_cnt_r;
    blk_cnt_nxt  = blk_cnt_r;
    mark_nxt     = mark_r;
    free_wr      = 1'b0;
    pend_wr      = 1'b0;
    blk_app      = 1'b0;
    blk_shift    = 1'b0;
    gnt_idx      = '0;
    valid_nxt    = 1'b0;
    stat_nxt     = ST_OK;
    unique case (req_r)
      REQ_ALLOC: begin
        if (free_cnt_r == '0) begin
          stat_nxt = ST_EMPTY;
        end else begin
          free_cnt_nxt = free_m1;
          gnt_idx      = flo_r ? fidx_r : frd_r;
          valid_nxt    = 1'b1;
          if (free_m1 < mark_r) mark_nxt = free_m1;
        end
      end
      REQ_FETCH: begin
        if (pend_cnt_r == '0) begin
          stat_nxt = ST_EMPTY;
        end else begin
          pend_cnt_nxt = pend_m1;
          gnt_idx      = prd_r;
          valid_nxt    = 1'b1;
        end
      end
      REQ_BLOCK: begin
        if (fid_bad || tag_r == '0) begin
          stat_nxt = ST_BADARG;
        end else if (blk_cnt_r == FULL_CNT) begin
          stat_nxt = ST_FULL;
        end else begin
          blk_app     = 1'b1;
          blk_cnt_nxt = blk_cnt_r + CNT_W'(1);
        end
      end
      REQ_DONE: begin
        if (fid_bad) begin
          stat_nxt = ST_BADARG;
        end else if (free_cnt_r == FULL_CNT) begin
          stat_nxt = ST_FULL;
        end else begin
          free_wr      = 1'b1;
          free_cnt_nxt = free_cnt_r + CNT_W'(1);
        end
      end
      REQ_UNBLOCK: begin
        if (tag_r == '0) begin
          stat_nxt = ST_BADARG;
        end else if (!hit) begin
          stat_nxt = ST_EMPTY;
        end else if (pend_cnt_r == FULL_CNT) begin
          stat_nxt = ST_FULL;
        end else begin
          pend_wr      = 1'b1;
          blk_shift    = 1'b1;
          pend_cnt_nxt = pend_cnt_r + CNT_W'(1);
          blk_cnt_nxt  = blk_cnt_r - CNT_W'(1);
        end
      end
      default: stat_nxt = ST_BADARG;
    endcase
  end

  assign gnt_ext = {{FID_W{1'b0}}, gnt_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r <= FULL_CNT;
      pend_cnt_r <= '0;
      blk_cnt_r  <= '0;
      mark_r     <= FULL_CNT;
    end else if (cmd.exec) begin
      free_cnt_r <= free_cnt_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      blk_cnt_r  <= blk_cnt_nxt;
      mark_r     <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      gnt_r   <= gnt_ext[FID_W-1:0];
      valid_r <= valid_nxt;
      stat_r  <= stat_nxt;
      work_r  <= (free_cnt_nxt < FULL_CNT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && free_wr) free_mem[free_cnt_r[IDX_W-1:0]] <= fid_idx;
    if (cmd.load) frd_r <= free_mem[free_m1[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && pend_wr) pend_mem[pend_cnt_r[IDX_W-1:0]] <= hit_ctx;
    if (cmd.load) prd_r <= pend_mem[pend_m1[IDX_W-1:0]];
  end

  // Blocked list cells: append at the tail, or shift down over the hit.
  always_ff @(posedge clk) begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (cmd.exec && blk_app && CNT_W'(i) == blk_cnt_r) begin
        blk_ctx_r[i] <= fid_idx;
        blk_tag_r[i] <= tag_r;
      end else if (cmd.exec && blk_shift && pm[i] && i < POOL_SIZE - 1) begin
        blk_ctx_r[i] <= blk_ctx_r[(i + 1) % POOL_SIZE];
        blk_tag_r[i] <= blk_tag_r[(i + 1) % POOL_SIZE];
      end
    end
  end

  assign out_granted_fiber = gnt_r;
  assign out_fiber_valid   = valid_r;
  assign out_status        = stat_r;
  assign out_has_work      = work_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= FULL_CNT && pend_cnt_r <= FULL_CNT && blk_cnt_r <= FULL_CNT)
    else $error("count above pool size");

  a_mark: assert property (@(posedge clk) disable iff (!rst_n)
    mark_r <= free_cnt_r)
    else $error("free stack low mark above free count");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.exec |=> $stable(free_cnt_r) && $stable(pend_cnt_r) && $stable(blk_cnt_r))
    else $error("count changed outside execute");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> (!valid_r || stat_r == ST_OK))
    else $error("granted context with error status");

  a_one_hot_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $onehot0(first))
    else $error("more than one oldest match");

endmodule

// ----- rtl/core/fiber_pool_scheduler.sv -----
// ----------------------------------------------------------------------------
// fiber_pool_scheduler: worker context pool with free, pending and wait lists
// Allocate, fetch pending, block, done and unblock by tag over a fixed pool.
//
//   channel   handshake           payload
//   request   start / busy        in_req_type, in_fiber_id, in_block_tag
//   result    out_strobe          out_granted_fiber, out_fiber_valid,
//                                 out_status, out_has_work
//
// A request is taken when start is high and busy is low. Each request
// is first captured, with the stack tops read and the tag compared
// against every blocked entry, and then executed. The result shows for one
// cycle after that, while the next request may already be taken; a new
// request is not taken while one executes. Reset is synchronous and needs no
// clearing pass. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module fiber_pool_scheduler #(
  parameter int POOL_SIZE = fps_pkg::POOL_SIZE_DEF,
  parameter int TAG_BITS  = fps_pkg::TAG_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [fps_pkg::REQ_W-1:0]    in_req_type,
  input  logic [fps_pkg::FID_W-1:0]    in_fiber_id,
  input  logic [fps_pkg::INTAG_W-1:0]  in_block_tag,
  output logic                         out_strobe,
  output logic [fps_pkg::FID_W-1:0]    out_granted_fiber,
  output logic                         out_fiber_valid,
  output logic [fps_pkg::STAT_W-1:0]   out_status,
  output logic                         out_has_work
);
  import fps_pkg::*;

  fps_cmd_t cmd;

  fps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .out_strobe (out_strobe)
  );

  fps_dp #(
    .POOL_SIZE (POOL_SIZE),
    .TAG_BITS  (TAG_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_req_type       (in_req_type),
    .in_fiber_id       (in_fiber_id),
    .in_block_tag      (in_block_tag),
    .out_granted_fiber (out_granted_fiber),
    .out_fiber_valid   (out_fiber_valid),
    .out_status        (out_status),
    .out_has_work      (out_has_work)
  );

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the fiber pool scheduler
// A driver feeds requests from a queue filled up front and a monitor checks
// every strobed result against a cycle-free predictor of the free, pending
// and blocked lists. Directed corner cases come first, then random mixes,
// bursts and fill sequences under several sender idle rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import fps_pkg::*;

  localparam int POOL = POOL_SIZE_DEF;
  localparam int LIMIT = 200000;
  localparam int ITEMS = 600;
  localparam logic [REQ_W-1:0] REQ_MAX = '1;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [FID_W-1:0]   fid;
    logic [INTAG_W-1:0] tag;
    int                 idle_pct;
    bit                 drain;
  } sched_req_t;

  typedef struct packed {
    logic [FID_W-1:0]  fiber;
    logic              valid;
    logic [STAT_W-1:0] status;
    logic              has_work;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [FID_W-1:0] in_fiber_id = '0;
  logic [INTAG_W-1:0] in_block_tag = '0;
  logic out_strobe;
  logic [FID_W-1:0] out_granted_fiber;
  logic out_fiber_valid;
  logic [STAT_W-1:0] out_status;
  logic out_has_work;

  sched_req_t req_q[$];
  sched_res_t result_q[$];
  bit took = 1'b0;
  int cur_idle = 0;
  int issued = 0;
  int checked = 0;
  int errors = 0;
  int cycles = 0;
  int stat_seen[4] = '{0, 0, 0, 0};

  logic [FID_W-1:0] free_ctx[POOL];
  int free_n;
  logic [FID_W-1:0] pend_ctx[POOL];
  int pend_n;
  logic [FID_W-1:0] blk_ctx[POOL];
  logic [INTAG_W-1:0] blk_tag[POOL];
  int blk_n;

  fiber_pool_scheduler dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_fiber_id(in_fiber_id),
    .in_block_tag(in_block_tag),
    .out_strobe(out_strobe),
    .out_granted_fiber(out_granted_fiber),
    .out_fiber_valid(out_fiber_valid),
    .out_status(out_status),
    .out_has_work(out_has_work)
  );

  always #10 clk = ~clk;

  function automatic sched_res_t schedule_request(logic [REQ_W-1:0] req,
                                                  logic [FID_W-1:0] fid,
                                                  logic [INTAG_W-1:0] tag);
    sched_res_t r;
    int hit;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    case (req)
      REQ_ALLOC: begin
        if (free_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          free_n--;
          r.fiber = free_ctx[free_n];
          r.valid = 1'b1;
        end
      end
      REQ_FETCH: begin
        if (pend_n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pend_n--;
          r.fiber = pend_ctx[pend_n];
          r.valid = 1'b1;
        end
      end
      REQ_BLOCK: begin
        if (int'(fid) >= POOL || tag == '0) begin
          r.status = ST_BADARG;
        end else if (blk_n >= POOL) begin
          r.status = ST_FULL;
        end else begin
          blk_ctx[blk_n] = fid;
          blk_tag[blk_n] = tag;
          blk_n++;
        end
      end
      REQ_DONE: begin
        if (int'(fid) >= POOL) begin
          r.status = ST_BADARG;
        end else if (free_n >= POOL) begin
          r.status = ST_FULL;
        end else begin
          free_ctx[free_n] = fid;
          free_n++;
        end
      end
      REQ_UNBLOCK: begin
        if (tag == '0) begin
          r.status = ST_BADARG;
        end else begin
          for (int i = 0; i < blk_n; i++) begin
            if (hit < 0 && blk_tag[i] == tag) begin
              hit = i;
            end
          end
          if (hit < 0) begin
            r.status = ST_EMPTY;
          end else if (pend_n >= POOL) begin
            r.status = ST_FULL;
          end else begin
            pend_ctx[pend_n] = blk_ctx[hit];
            pend_n++;
            for (int i = hit; i + 1 < blk_n; i++) begin
              blk_ctx[i] = blk_ctx[i + 1];
              blk_tag[i] = blk_tag[i + 1];
            end
            blk_n--;
          end
        end
      end
      default: begin
        r.status = ST_BADARG;
      end
    endcase
    r.has_work = (free_n < POOL);
    return r;
  endfunction

  task automatic add_request(logic [REQ_W-1:0] req, logic [FID_W-1:0] fid,
                             logic [INTAG_W-1:0] tag, bit drain = 1'b0);
    sched_req_t it;
    it.req = req;
    it.fid = fid;
    it.tag = tag;
    it.idle_pct = cur_idle;
    it.drain = drain;
    req_q.push_back(it);
  endtask

  function automatic logic [INTAG_W-1:0] pick_tag();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      return '0;
    end else if (sel < 25) begin
      return INTAG_W'($urandom);
    end else if (sel < 35) begin
      return '1;
    end
    return INTAG_W'($urandom_range(1, 3));
  endfunction

  function automatic logic [REQ_W-1:0] pick_req();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      return REQ_ALLOC;
    end else if (sel < 35) begin
      return REQ_FETCH;
    end else if (sel < 55) begin
      return REQ_BLOCK;
    end else if (sel < 75) begin
      return REQ_DONE;
    end else if (sel < 95) begin
      return REQ_UNBLOCK;
    end
    return REQ_W'($urandom_range(REQ_UNBLOCK + 1, REQ_MAX));
  endfunction

  task automatic add_fill();
    logic [INTAG_W-1:0] t;
    int k;
    t = INTAG_W'($urandom_range(1, 3));
    k = $urandom_range(POOL - 2, POOL + 2);
    for (int i = 0; i < k; i++) begin
      add_request(REQ_BLOCK, FID_W'($urandom), t);
    end
    for (int i = 0; i < k + 2; i++) begin
      add_request(REQ_UNBLOCK, FID_W'($urandom), t);
    end
    for (int i = 0; i < k + 2; i++) begin
      add_request(REQ_FETCH, FID_W'($urandom), INTAG_W'($urandom));
    end
  endtask

  task automatic add_phase(int pct, int n, bit with_fill);
    int stop;
    int sel;
    int len;
    logic [REQ_W-1:0] op;
    logic [INTAG_W-1:0] t;
    cur_idle = pct;
    stop = req_q.size() + n;
    add_request(pick_req(), FID_W'($urandom), pick_tag(), 1'b1);
    if (with_fill) begin
      add_fill();
    end
    while (req_q.size() < stop) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        add_request(pick_req(), FID_W'($urandom), pick_tag());
      end else if (sel < 19) begin
        op = REQ_W'($urandom_range(REQ_ALLOC, REQ_UNBLOCK));
        t = INTAG_W'($urandom_range(1, 3));
        len = $urandom_range(2, POOL + 8);
        for (int i = 0; i < len; i++) begin
          add_request(op, FID_W'($urandom), t);
        end
      end else begin
        add_fill();
      end
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAIL fiber_pool_scheduler");
      $finish;
    end
  end

  always @(negedge clk) begin : driver
    sched_req_t nxt;
    if (rst_n && (!start || took)) begin
      if (req_q.size() != 0 && req_q[0].drain && result_q.size() != 0) begin
        start <= 1'b0;
      end else if (req_q.size() != 0 && $urandom_range(0, 99) >= req_q[0].idle_pct) begin
        nxt = req_q.pop_front();
        start <= 1'b1;
        in_req_type <= nxt.req;
        in_fiber_id <= nxt.fid;
        in_block_tag <= nxt.tag;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    sched_res_t want;
    if (rst_n && out_strobe) begin
      if (result_q.size() == 0) begin
        $error("result strobed with no request outstanding");
        errors++;
      end else begin
        want = result_q.pop_front();
        checked++;
        stat_seen[want.status]++;
        if (out_granted_fiber !== want.fiber) begin
          $error("granted_fiber: expected %0d, got %0d", want.fiber, out_granted_fiber);
          errors++;
        end
        if (out_fiber_valid !== want.valid) begin
          $error("fiber_valid: expected %0d, got %0d", want.valid, out_fiber_valid);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_has_work !== want.has_work) begin
          $error("has_work: expected %0d, got %0d", want.has_work, out_has_work);
          errors++;
        end
      end
    end
    took <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      result_q.push_back(schedule_request(in_req_type, in_fiber_id, in_block_tag));
      issued++;
    end
  end

  initial begin
    for (int i = 0; i < POOL; i++) begin
      free_ctx[i] = FID_W'(i);
    end
    free_n = POOL;
    pend_n = 0;
    blk_n = 0;

    add_request(REQ_FETCH, '0, '0);
    add_request(REQ_ALLOC, '1, '1);
    add_request(REQ_DONE, '1, '0);
    add_request(REQ_DONE, '0, '1);
    add_request(REQ_BLOCK, '0, '0);
    add_request(REQ_UNBLOCK, '1, '0);
    add_request(REQ_UNBLOCK, '0, INTAG_W'(5));
    for (int r = REQ_UNBLOCK + 1; r <= REQ_MAX; r++) begin
      add_request(REQ_W'(r), '1, '1);
    end
    add_request(REQ_ALLOC, '0, '0);
    add_request(REQ_BLOCK, '1, '1);
    add_request(REQ_BLOCK, '0, INTAG_W'(1));
    add_request(REQ_BLOCK, FID_W'(16), '1);
    add_request(REQ_UNBLOCK, '0, '1);
    add_request(REQ_UNBLOCK, '0, '1);
    add_request(REQ_UNBLOCK, '0, INTAG_W'(1));
    for (int i = 0; i < 4; i++) begin
      add_request(REQ_FETCH, '1, '1);
    end
    add_request(REQ_DONE, '1, '1);
    add_request(REQ_ALLOC, '0, '0);
    add_request(REQ_UNBLOCK, '0, '1);

    add_phase(0, ITEMS / 4, 1'b1);
    add_phase(62, ITEMS / 4, 1'b0);
    add_phase(0, ITEMS / 4, 1'b0);
    add_phase(37, ITEMS / 4, 1'b1);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || start) begin
      @(posedge clk);
    end
    while (result_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("Issued %0d requests over four idle phases, %0d results checked.", issued,
             checked);
    $display("Statuses seen: ok %0d, empty or no match %0d, bad argument %0d, full %0d.",
             stat_seen[ST_OK], stat_seen[ST_EMPTY], stat_seen[ST_BADARG], stat_seen[ST_FULL]);
    if (errors == 0) begin
      $display("PASS fiber_pool_scheduler");
    end else begin
      $display("FAIL fiber_pool_scheduler");
    end
    $finish;
  end

endmodule
